### rtl/core/bda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the BCD digit width, the ASCII offset, the double-dabble digit
// correction and the queue status struct.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int DIGIT_W       = 4;
    localparam int BITS_PER_STEP = 4;

    localparam logic [5:0] ASCII_ZERO    = 6'd48;
    localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
    localparam logic [3:0] DABBLE_OFFSET = 4'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Correct one BCD digit before the next shift.
    function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] nib);
        return (nib >= DABBLE_LIMIT) ? nib + DABBLE_OFFSET : nib;
    endfunction

endpackage
`default_nettype wire

### rtl/core/bda_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_front: input side of the converter
// Accepts one value, converts it to packed BCD with a double-dabble loop
// that retires four input bits per cycle, finds the leading digit and
// pushes the result into the queue.
// ----------------------------------------------------------------------------
module bda_front #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10,
    parameter int IDX_W      = 4
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic [31:0]                                value,
    output logic                                            push,
    output logic [IDX_W+DIGITS*bda_pkg::DIGIT_W-1:0]        push_data,
    input  bda_pkg::q_stat_t                                q_stat
);

    localparam int STEPS  = (VALUE_BITS + bda_pkg::BITS_PER_STEP - 1) / bda_pkg::BITS_PER_STEP;
    localparam int PAD_W  = STEPS * bda_pkg::BITS_PER_STEP;
    localparam int BCD_W  = DIGITS * bda_pkg::DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [1:0] {
        IDLE,
        CONV,
        PUSH
    } state_t;

    state_t                state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [PAD_W-1:0]      bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [PAD_W-1:0]      value_pad;
    logic [BCD_W+PAD_W-1:0] dabble_next;
    logic [BCD_W+PAD_W-1:0] acc;
    logic [IDX_W-1:0]      msd_idx;

    // Drop input bits at or above VALUE_BITS.
    generate
        if (VALUE_BITS <= 32) begin : g_narrow
            assign value_pad = PAD_W'(value[VALUE_BITS-1:0]);
        end
        else begin : g_wide
            assign value_pad = PAD_W'(value);
        end
    endgenerate

    always_comb
    begin
        acc = {bcd_reg, bin_reg};
        for (int b = 0; b < bda_pkg::BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                acc[PAD_W + bda_pkg::DIGIT_W*d +: bda_pkg::DIGIT_W] =
                    bda_pkg::dabble_adjust(acc[PAD_W + bda_pkg::DIGIT_W*d +: bda_pkg::DIGIT_W]);
            end
            acc = acc << 1;
        end
        dabble_next = acc;
    end

    // Index of the highest nonzero digit; zero keeps a single digit.
    always_comb
    begin
        msd_idx = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[bda_pkg::DIGIT_W*d +: bda_pkg::DIGIT_W] != '0)
            begin
                msd_idx = IDX_W'(d);
            end
        end
    end

    assign in_ready  = (state_reg == IDLE);
    assign push      = (state_reg == PUSH) && !q_stat.full;
    assign push_data = {msd_idx, bcd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        bin_reg   <= value_pad;
                        bcd_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= CONV;
                    end
                end
                CONV:
                begin
                    {bcd_reg, bin_reg} <= dabble_next;
                    step_reg           <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= PUSH;
                    end
                end
                PUSH:
                begin
                    if (!q_stat.full)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/bda_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_queue: two-entry queue between front and back
// Holds converted numbers so the converter and the digit emitter stall
// independently.
// ----------------------------------------------------------------------------
module bda_queue #(
    parameter int WIDTH = 44
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output bda_pkg::q_stat_t      q_stat
);

    logic [1:0][WIDTH-1:0] entry_reg;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/bda_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_back: digit emitter
// Takes one converted number from the queue and sends its digits as ASCII,
// most significant first, one per accepted output item.
// ----------------------------------------------------------------------------
module bda_back #(
    parameter int DIGITS = 10,
    parameter int IDX_W  = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [IDX_W+DIGITS*bda_pkg::DIGIT_W-1:0] pop_data,
    input  bda_pkg::q_stat_t                           q_stat,
    output logic                                       pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [5:0]                                 digit_char,
    output logic                                       last
);

    localparam int BCD_W = DIGITS * bda_pkg::DIGIT_W;

    logic [DIGITS-1:0][bda_pkg::DIGIT_W-1:0] digits_reg;
    logic [DIGITS-1:0][bda_pkg::DIGIT_W-1:0] digits_in;
    logic [IDX_W-1:0]                        pos_reg;
    logic                                    busy_reg;
    logic                                    done;

    assign digits_in  = pop_data[BCD_W-1:0];
    assign out_valid  = busy_reg;
    assign last       = (pos_reg == '0);
    assign digit_char = bda_pkg::ASCII_ZERO + {2'b00, digits_reg[pos_reg]};
    assign done       = busy_reg && out_ready && last;
    // Refill straight after the final digit to avoid a bubble.
    assign pop        = (!busy_reg || done) && !q_stat.empty;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            digits_reg <= digits_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= pop_data[BCD_W +: IDX_W];
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && out_ready)
            begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/binary_to_decimal_ascii.sv
`default_nettype none
// Flow: an accepted value is converted in the CONV state, pushed into the queue
//   from the PUSH state and popped by the emitter; digits follow one per cycle while out_ready is high.
// Overlap: the front takes no new value until the last one is in the queue, so
//   conversion of one number overlaps emission of the one before.
// Reset: rst_n clears the converter state, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII converter
// Front converts each value to BCD, a short queue decouples it from the back,
// which emits digits most significant first with the final one marked.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       digit_char,
    output logic             last
);

    localparam int DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int ENTRY_W = IDX_W + DIGITS * bda_pkg::DIGIT_W;

    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;
    bda_pkg::q_stat_t   q_stat;

    bda_front #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .push      (q_push),
        .push_data (q_push_data),
        .q_stat    (q_stat)
    );

    bda_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat)
    );

    bda_back #(
        .DIGITS (DIGITS),
        .IDX_W  (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (q_pop_data),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last       (last)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
        else $error("digit outside ASCII 0-9");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("digit run broken before last digit");
`endif

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the binary to decimal ASCII converter
// Drives 32-bit numbers through the valid/ready input, takes or predicts the
// decimal digit stream of each one, and checks every emitted character and
// its last flag in order. Runs a directed table, then random numbers spread
// over all digit counts, under four idling and stalling profiles.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PER_PH = 40;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } digit_t;

    typedef struct {
        logic [31:0] num;
        string       text;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  digit_char;
    logic        last;

    digit_t      pending_digits[$];
    int          error_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;

    // Empty text means the row is checked against the predictor.
    stim_row_t directed_rows[] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{32'd99,         "99"},
        '{32'd100,        "100"},
        '{32'd255,        ""},
        '{32'd65535,      ""},
        '{32'd1234,       ""},
        '{32'd123456789,  ""},
        '{32'd999999999,  "999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'hFFFFFFFF,   "4294967295"},
        '{32'hFFFFFFFE,   "4294967294"},
        '{32'h80000000,   ""},
        '{32'h7FFFFFFF,   ""},
        '{32'hAAAAAAAA,   ""},
        '{32'h55555555,   ""},
        '{32'd4000000000, ""},
        '{32'd3999999999, ""},
        '{32'd0,          "0"}
    };

    binary_to_decimal_ascii #(
        .VALUE_BITS(32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digit_char(digit_char),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Queue the decimal characters of a number, most significant first.
    task automatic predict_digits(input logic [31:0] num);
        logic [5:0]  rev[$];
        logic [31:0] rest;
        digit_t      d;
        rest = num;
        do
        begin
            rev.push_front(bda_pkg::ASCII_ZERO + 6'(rest % 32'd10));
            rest = rest / 32'd10;
        end
        while (rest != 32'd0);
        foreach (rev[i])
        begin
            d.ch   = rev[i];
            d.last = (i == rev.size() - 1);
            pending_digits.push_back(d);
        end
    endtask

    task automatic expect_text(input string text);
        digit_t d;
        byte    c;
        for (int i = 0; i < text.len(); i++)
        begin
            c      = text[i];
            d.ch   = c[5:0];
            d.last = (i == text.len() - 1);
            pending_digits.push_back(d);
        end
    endtask

    // Offer one number; return after it is accepted, at the next falling edge.
    task automatic send_number(input logic [31:0] num, input string text);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            value    <= $urandom;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= num;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (text.len() != 0)
            expect_text(text);
        else
            predict_digits(num);
        @(negedge clk);
    endtask

    // Spread random numbers evenly over digit counts, with some raw words.
    function automatic logic [31:0] random_number();
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;
        if ($urandom_range(99) < 20)
            return $urandom;
        if ($urandom_range(99) < 3)
            return 32'd0;
        ndig = $urandom_range(10, 1);
        lo = (ndig == 1) ? 0 : 1;
        hi = 10;
        for (int i = 1; i < ndig; i++)
        begin
            lo = (i == 1) ? 10 : lo * 10;
            hi = hi * 10;
        end
        if (hi > 64'hFFFFFFFF + 1)
            hi = 64'hFFFFFFFF + 1;
        return 32'($urandom_range(32'(hi - 1), 32'(lo)));
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        digit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                         $time, digit_char, last);
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit_char !== want.ch)
                begin
                    error_count++;
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, want.ch, digit_char);
                end
                if (last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        value              = 32'd0;
        out_ready          = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_number(directed_rows[i].num, directed_rows[i].text);

        // Profiles: no idling, sender idle, receiver stalling, both lightly.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 75;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 75;
                end
                default:
                begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PH; n++)
                send_number(random_number(), "");
        end
        in_valid <= 1'b0;

        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
